[hw/rtl/bcsc_pkg.sv]
// shared types, codes and constants of the battery charge state controller
`timescale 1ns / 1ps

package bcsc_pkg;

  // event codes
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_STOP  = 2'd2;

  // charging modes
  localparam logic [2:0] MODE_IDLE     = 3'd0;
  localparam logic [2:0] MODE_CHARGING = 3'd1;
  localparam logic [2:0] MODE_COLD     = 3'd2;
  localparam logic [2:0] MODE_HOT      = 3'd3;
  localparam logic [2:0] MODE_COMPLETE = 3'd4;

  // manual start status codes
  localparam logic [1:0] START_OK    = 2'd0;
  localparam logic [1:0] START_COLD  = 2'd1;
  localparam logic [1:0] START_HOT   = 2'd2;
  localparam logic [1:0] START_NO_AC = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_UNDER_TEMP   = 3'd0;
  localparam logic [2:0] REG_OVER_TEMP    = 3'd1;
  localparam logic [2:0] REG_OVER_VOLT    = 3'd2;
  localparam logic [2:0] REG_APPROACH     = 3'd3;
  localparam logic [2:0] REG_REENABLE     = 3'd4;
  localparam logic [2:0] REG_STEP_TABLE   = 3'd5;
  localparam logic [2:0] REG_FULL_VOLT    = 3'd6;
  localparam logic [2:0] REG_IDLE_DRIVE   = 3'd7;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int TABLE_LEN  = 4;
  localparam int DEF_NUM_STEPS = 4;

  // configuration reset values
  localparam logic signed [15:0] RST_UNDER_TEMP = 16'sd0;
  localparam logic signed [15:0] RST_OVER_TEMP  = 16'sd450;
  localparam logic [15:0]        RST_OVER_VOLT  = 16'd4200;
  localparam logic [15:0]        RST_APPROACH   = 16'd50;
  localparam logic [15:0]        RST_REENABLE   = 16'd100;

  // configuration bundle
  typedef struct packed {
    logic signed [15:0] under_temp_limit;
    logic signed [15:0] over_temp_limit;
    logic [15:0]        over_volt_limit;
    logic [15:0]        approach_margin;
    logic [15:0]        reenable_drop;
    logic [63:0]        current_step_table;
    logic [15:0]        full_volt_drive;
    logic [31:0]        idle_drive_pair;
  } cfg_t;

  // one input request
  typedef struct packed {
    logic [1:0]         func;
    logic               ac_disconnected;
    logic signed [15:0] lowest_temp;
    logic signed [15:0] highest_temp;
    logic [15:0]        highest_cell_volt;
  } item_t;

  // one result
  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] current_drive;
    logic [15:0] voltage_drive;
    logic        fan_on;
    logic [1:0]  start_status;
  } result_t;

endpackage

[hw/rtl/battery_charge_state_controller_unit.sv]
// top level of the battery charge state controller
`timescale 1ns / 1ps

// Battery charge state controller. Each request is one event (service tick,
// manual start or manual stop) with the AC flag, pack temperatures and the
// highest cell voltage; each request gives exactly one result showing the
// mode, drive values and fan after the event, plus the start status. One
// request is accepted every clock cycle: the request sits in an input
// register, the mode rules are a single pass of compares and selects, and
// the result is registered, so a result passes from the input register
// to the result register, and only the output side taking results sets
// the throughput. The user must write configuration registers via the
// cfg_ port only while no request is in flight; the block does not
// enforce it; NUM_STEPS sets how many step table entries are used (1 to 4).

module battery_charge_state_controller_unit import bcsc_pkg::*; #(
  parameter int NUM_STEPS = DEF_NUM_STEPS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // requests
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_func,
  input  logic                  in_ac_disconnected,
  input  logic signed [15:0]    in_lowest_temp,
  input  logic signed [15:0]    in_highest_temp,
  input  logic [15:0]           in_highest_cell_volt,
  // results
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_mode,
  output logic [15:0]           out_current_drive,
  output logic [15:0]           out_voltage_drive,
  output logic                  out_fan_on,
  output logic [1:0]            out_start_status
);

  cfg_t    cfg;
  item_t   in_item, item;
  logic    item_valid, take;
  result_t result;

  assign in_item.func              = in_func;
  assign in_item.ac_disconnected   = in_ac_disconnected;
  assign in_item.lowest_temp       = in_lowest_temp;
  assign in_item.highest_temp      = in_highest_temp;
  assign in_item.highest_cell_volt = in_highest_cell_volt;

  // configuration registers
  bcsc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // input register
  bcsc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  // mode logic and result register
  bcsc_core #(
    .NUM_STEPS (NUM_STEPS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result     (result)
  );

  assign out_mode          = result.mode;
  assign out_current_drive = result.current_drive;
  assign out_voltage_drive = result.voltage_drive;
  assign out_fan_on        = result.fan_on;
  assign out_start_status  = result.start_status;

endmodule

[hw/rtl/bcsc_cfg_regs.sv]
// configuration register file of the charge state controller
`timescale 1ns / 1ps

module bcsc_cfg_regs import bcsc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  // register writes by index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.under_temp_limit   <= RST_UNDER_TEMP;
      cfg_r.over_temp_limit    <= RST_OVER_TEMP;
      cfg_r.over_volt_limit    <= RST_OVER_VOLT;
      cfg_r.approach_margin    <= RST_APPROACH;
      cfg_r.reenable_drop      <= RST_REENABLE;
      cfg_r.current_step_table <= '0;
      cfg_r.full_volt_drive    <= '0;
      cfg_r.idle_drive_pair    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_UNDER_TEMP: cfg_r.under_temp_limit   <= $signed(cfg_wdata[15:0]);
        REG_OVER_TEMP:  cfg_r.over_temp_limit    <= $signed(cfg_wdata[15:0]);
        REG_OVER_VOLT:  cfg_r.over_volt_limit    <= cfg_wdata[15:0];
        REG_APPROACH:   cfg_r.approach_margin    <= cfg_wdata[15:0];
        REG_REENABLE:   cfg_r.reenable_drop      <= cfg_wdata[15:0];
        REG_STEP_TABLE: cfg_r.current_step_table <= cfg_wdata;
        REG_FULL_VOLT:  cfg_r.full_volt_drive    <= cfg_wdata[15:0];
        REG_IDLE_DRIVE: cfg_r.idle_drive_pair    <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[hw/rtl/bcsc_in_stage.sv]
// input register stage holding one request ahead of the mode logic
`timescale 1ns / 1ps

module bcsc_in_stage import bcsc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  take,
  output logic  item_valid,
  output item_t item
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  load;

  // space when empty or when the held request moves on this cycle
  assign in_ready = !valid_r || take;
  assign load     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

[hw/rtl/bcsc_core.sv]
// charging mode state, next-state rules and the result register
`timescale 1ns / 1ps

module bcsc_core import bcsc_pkg::*; #(
  parameter int NUM_STEPS = DEF_NUM_STEPS
) (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    item_valid,
  input  item_t   item,
  output logic    take,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t result
);

  localparam int STEP_W = (NUM_STEPS > 1) ? $clog2(NUM_STEPS) : 1;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NUM_STEPS - 1);

  // state registers
  logic [2:0]        mode_r, mode_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [15:0]       cur_r, cur_nxt;
  logic [15:0]       volt_r, volt_nxt;
  logic              fan_r, fan_nxt;
  logic [1:0]        status_nxt;

  // result register
  logic    out_valid_r, out_valid_nxt;
  result_t result_r;

  logic [TABLE_LEN-1:0][15:0] tab;
  logic [STEP_W-1:0]          step_inc;
  logic                       cold, hot, at_limit, approach, below_rearm;
  logic signed [16:0]         approach_thr, rearm_thr, volt_s;

  // request moves on when the result register is free or being emptied
  assign take = item_valid && (!out_valid_r || out_ready);

  // threshold compares, voltage thresholds taken with sign
  assign tab          = cfg.current_step_table;
  assign volt_s       = $signed({1'b0, item.highest_cell_volt});
  assign approach_thr = $signed({1'b0, cfg.over_volt_limit})
                      - $signed({1'b0, cfg.approach_margin});
  assign rearm_thr    = $signed({1'b0, cfg.over_volt_limit})
                      - $signed({1'b0, cfg.reenable_drop});
  assign cold         = item.lowest_temp <= cfg.under_temp_limit;
  assign hot          = item.highest_temp >= cfg.over_temp_limit;
  assign at_limit     = item.highest_cell_volt >= cfg.over_volt_limit;
  assign approach     = volt_s >= approach_thr;
  assign below_rearm  = volt_s < rearm_thr;
  assign step_inc     = step_r + 1'b1;

  // next state for one event
  always_comb begin
    mode_nxt   = mode_r;
    step_nxt   = step_r;
    cur_nxt    = cur_r;
    volt_nxt   = volt_r;
    fan_nxt    = fan_r;
    status_nxt = START_OK;
    case (item.func)
      FUNC_TICK: begin
        if (item.ac_disconnected) begin
          // cable gone: drop back to idle drives
          if (mode_r != MODE_IDLE) begin
            mode_nxt = MODE_IDLE;
            cur_nxt  = cfg.idle_drive_pair[15:0];
            volt_nxt = cfg.idle_drive_pair[31:16];
            fan_nxt  = 1'b0;
          end
        end else begin
          case (mode_r)
            MODE_IDLE: begin
              if (cold) begin
                mode_nxt = MODE_COLD;
              end else if (hot) begin
                mode_nxt = MODE_HOT;
              end else begin
                mode_nxt = MODE_CHARGING;
                step_nxt = '0;
                cur_nxt  = tab[0];
                volt_nxt = cfg.full_volt_drive;
                fan_nxt  = 1'b1;
              end
            end
            MODE_CHARGING: begin
              if (cold) begin
                // cold wins over completion
                mode_nxt = MODE_COLD;
                cur_nxt  = cfg.idle_drive_pair[15:0];
                volt_nxt = cfg.idle_drive_pair[31:16];
                fan_nxt  = 1'b0;
                if (!at_limit && approach && step_r < STEP_LAST) begin
                  step_nxt = step_inc;
                end
              end else if (at_limit) begin
                mode_nxt = MODE_COMPLETE;
                cur_nxt  = cfg.idle_drive_pair[15:0];
                volt_nxt = cfg.idle_drive_pair[31:16];
                fan_nxt  = 1'b0;
              end else if (approach && step_r < STEP_LAST) begin
                // step the current down towards the limit
                step_nxt = step_inc;
                cur_nxt  = tab[2'(step_inc)];
              end
            end
            MODE_COLD: begin
              if (!cold) begin
                mode_nxt = MODE_CHARGING;
                step_nxt = '0;
                cur_nxt  = tab[0];
                volt_nxt = cfg.full_volt_drive;
                fan_nxt  = 1'b1;
              end
            end
            MODE_HOT: begin
              if (!hot) begin
                mode_nxt = MODE_CHARGING;
                step_nxt = '0;
                cur_nxt  = tab[0];
                volt_nxt = cfg.full_volt_drive;
                fan_nxt  = 1'b1;
              end
            end
            MODE_COMPLETE: begin
              if (below_rearm) begin
                mode_nxt = MODE_IDLE;
              end
            end
            default: ;
          endcase
        end
      end
      FUNC_START: begin
        if (item.ac_disconnected) begin
          status_nxt = START_NO_AC;
        end else if (cold) begin
          status_nxt = START_COLD;
        end else if (hot) begin
          status_nxt = START_HOT;
        end else begin
          mode_nxt = MODE_CHARGING;
          step_nxt = '0;
          cur_nxt  = tab[0];
          volt_nxt = cfg.full_volt_drive;
          fan_nxt  = 1'b1;
        end
      end
      FUNC_STOP: begin
        mode_nxt = MODE_IDLE;
        cur_nxt  = cfg.idle_drive_pair[15:0];
        volt_nxt = cfg.idle_drive_pair[31:16];
        fan_nxt  = 1'b0;
      end
      default: ;
    endcase
  end

  // result register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      step_r      <= '0;
      cur_r       <= '0;
      volt_r      <= '0;
      fan_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        mode_r <= mode_nxt;
        step_r <= step_nxt;
        cur_r  <= cur_nxt;
        volt_r <= volt_nxt;
        fan_r  <= fan_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take) begin
      result_r.mode          <= mode_nxt;
      result_r.current_drive <= cur_nxt;
      result_r.voltage_drive <= volt_nxt;
      result_r.fan_on        <= fan_nxt;
      result_r.start_status  <= status_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

  // step index stays within the table
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= STEP_LAST)
    else $error("step index past last entry");

  // fan runs exactly while charging
  a_fan_mode: assert property (@(posedge clk) disable iff (!rst_n)
    fan_r == (mode_r == MODE_CHARGING))
    else $error("fan and mode disagree");

  // mode only moves when a request is taken
  a_mode_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !take |=> $stable(mode_r))
    else $error("mode changed without a request");

  // a shown result with the fan on is a charging result
  a_out_fan: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && result_r.fan_on) |-> (result_r.mode == MODE_CHARGING))
    else $error("result fan and mode disagree");

endmodule
